### hdl/ascii_number_to_integer_macros.svh
// ============================================================================
// ASCII number converter assertion macros
// Shared concurrent assertion forms used by the converter RTL.
// ============================================================================
`ifndef ASCII_NUMBER_TO_INTEGER_MACROS_SVH
`define ASCII_NUMBER_TO_INTEGER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ATOI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ATOI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/atoi_pkg.sv
// ============================================================================
// atoi_pkg
// Widths, codes and constants shared by the ASCII number converter.
// ============================================================================
`timescale 1ns / 1ps

package atoi_pkg;

  // Field widths.
  localparam int CharW = 8;
  localparam int KindW = 2;
  localparam int TwW   = 2;
  localparam int AccW  = 33;
  localparam int ValW  = 33;
  localparam int PosW  = 2;
  localparam int DigW  = 4;
  // Accumulator times sixteen plus a digit fits in this width.
  localparam int ProdW = AccW + 4;

  // Number kinds.
  localparam logic [KindW-1:0] KindUdec = 2'd0;
  localparam logic [KindW-1:0] KindSdec = 2'd1;
  localparam logic [KindW-1:0] KindHex  = 2'd2;

  // Target width codes; the unused code behaves as 32 bits.
  localparam logic [TwW-1:0] Tw8  = 2'd0;
  localparam logic [TwW-1:0] Tw16 = 2'd1;
  localparam logic [TwW-1:0] Tw32 = 2'd2;

  // Characters.
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowF  = 8'h66;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpF   = 8'h46;

  // Value limits, all as magnitudes in accumulator width.
  localparam logic [AccW-1:0] Uint32Max   = 33'h0_FFFF_FFFF;
  localparam logic [AccW-1:0] Int32Max    = 33'h0_7FFF_FFFF;
  localparam logic [AccW-1:0] Int32MinMag = 33'h0_8000_0000;
  localparam logic [AccW-1:0] Int8Max     = 33'd127;
  localparam logic [AccW-1:0] Int16Max    = 33'd32767;
  localparam logic [AccW-1:0] Uint8Max    = 33'd255;
  localparam logic [AccW-1:0] Uint16Max   = 33'd65535;

  // Character position handling.
  localparam logic [PosW-1:0] PosFirst     = 2'd0;
  localparam logic [PosW-1:0] PosSat       = 2'd3;
  localparam logic [PosW-1:0] HexPrefixLen = 2'd2;

endpackage

### hdl/atoi_in_if.sv
// ============================================================================
// atoi_in_if
// Character channel into the converter: valid/ready plus one character beat.
// ============================================================================
`timescale 1ns / 1ps

interface atoi_in_if;
  logic                         valid;
  logic                         ready;
  logic [atoi_pkg::CharW-1:0]   char_in;
  logic                         first_char;
  logic                         last_char;
  logic [atoi_pkg::KindW-1:0]   number_kind;
  logic [atoi_pkg::TwW-1:0]     target_width;

  modport source (
    output valid, char_in, first_char, last_char, number_kind, target_width,
    input  ready
  );
  modport sink (
    input  valid, char_in, first_char, last_char, number_kind, target_width,
    output ready
  );
endinterface

### hdl/atoi_out_if.sv
// ============================================================================
// atoi_out_if
// Result channel out of the converter: valid/ready plus one result beat.
// ============================================================================
`timescale 1ns / 1ps

interface atoi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [atoi_pkg::ValW-1:0]   value_out;
  logic                               range_error;

  modport source (
    output valid, value_out, range_error,
    input  ready
  );
  modport sink (
    input  valid, value_out, range_error,
    output ready
  );
endinterface

### hdl/ascii_number_to_integer.sv
// ============================================================================
// ascii_number_to_integer
// Converts a decimal or 0x-prefixed hex token, one character per beat, into
// a binary value truncated to 8, 16 or 32 bits, with a range error flag.
// ============================================================================
// Usage:
//   in_ch carries one character beat with its token flags, number kind and
//   target width. first_char clears the running state before the character
//   is used; last_char makes the block emit one result beat on out_ch.
//   Beats that are not last produce no result.
//   Latency: a result is valid on out_ch the cycle after its last character
//   is accepted. Throughput: one character per cycle, sustained across token
//   boundaries while out_ch takes results; the accumulator update and the
//   range check are done in the accept cycle, from the running state registers.
//   Reset clears the running state and empties the result register.
//   When the receiver stalls, the result register holds its beat and in_ch
//   stays open in the same cycle as the result is taken; while it is held
//   and not taken, in_ch.ready is low.
// ============================================================================
`timescale 1ns / 1ps

`include "ascii_number_to_integer_macros.svh"

module ascii_number_to_integer (
  input  logic        clk,
  input  logic        rst_n,
  atoi_in_if.sink     in_ch,
  atoi_out_if.source  out_ch
);
  import atoi_pkg::*;

  // Running token state.
  logic [AccW-1:0] acc_r, acc_nxt;
  logic            ovf_r, ovf_nxt;
  logic            neg_r, neg_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic signed [ValW-1:0] value_r;
  logic                   err_r;

  logic in_beat;
  logic out_beat;

  // State as seen by this character, after an optional clear.
  logic [AccW-1:0] acc_b;
  logic            ovf_b;
  logic            neg_b;
  logic [PosW-1:0] pos_b;

  logic            is_signed;
  logic            is_hex;
  logic            dig_ok;
  logic [DigW-1:0] dig_val;
  logic            take;
  logic            neg_set;
  logic [AccW-1:0] lim;
  logic [ProdW-1:0] acc_ext;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] sum;

  // Per-character next state (before the end-of-token clear).
  logic [AccW-1:0] acc_n;
  logic            ovf_n;
  logic            neg_n;

  // Result formatting.
  logic [AccW-1:0] pos_lim;
  logic [AccW-1:0] neg_lim;
  logic [AccW-1:0] umax;
  logic [AccW-1:0] sval;
  logic [ValW-1:0] value_c;
  logic            err_c;

  // Handshakes: the result register drains in the same cycle it refills.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_beat    = out_valid_r && out_ch.ready;

  assign is_signed = (in_ch.number_kind == KindSdec);
  assign is_hex    = (in_ch.number_kind == KindHex);

  // A first character starts from a clean state.
  assign acc_b = in_ch.first_char ? '0 : acc_r;
  assign ovf_b = in_ch.first_char ? 1'b0 : ovf_r;
  assign neg_b = in_ch.first_char ? 1'b0 : neg_r;
  assign pos_b = in_ch.first_char ? PosFirst : pos_r;

  // Digit decode for the current base.
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = '0;
    if (in_ch.char_in inside {[CharZero:CharNine]}) begin
      dig_ok  = 1'b1;
      dig_val = DigW'(in_ch.char_in - CharZero);
    end else if (is_hex && (in_ch.char_in inside {[CharLowA:CharLowF]})) begin
      dig_ok  = 1'b1;
      dig_val = DigW'(in_ch.char_in - CharLowA) + DigW'(10);
    end else if (is_hex && (in_ch.char_in inside {[CharUpA:CharUpF]})) begin
      dig_ok  = 1'b1;
      dig_val = DigW'(in_ch.char_in - CharUpA) + DigW'(10);
    end
  end

  // Sign and prefix handling decides whether the character is a digit slot.
  always_comb begin
    take    = 1'b1;
    neg_set = 1'b0;
    if (is_hex) begin
      take = (pos_b >= HexPrefixLen);
    end else if (pos_b == PosFirst) begin
      if (in_ch.char_in == CharPlus) begin
        take = 1'b0;
      end else if ((in_ch.char_in == CharMinus) && is_signed) begin
        take    = 1'b0;
        neg_set = 1'b1;
      end
    end
  end

  assign neg_n = neg_b | neg_set;

  // Overflow limit of the kind, as a magnitude.
  always_comb begin
    if (is_signed) begin
      lim = neg_n ? Int32MinMag : Int32Max;
    end else begin
      lim = Uint32Max;
    end
  end

  // Multiply by the base with shifts and add the digit.
  assign acc_ext = ProdW'(acc_b);
  assign prod    = is_hex ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
  assign sum     = prod + ProdW'(dig_val);

  // Accumulate, or raise the sticky overflow instead of updating.
  always_comb begin
    acc_n = acc_b;
    ovf_n = ovf_b;
    if (take && !ovf_b && dig_ok) begin
      if (sum > ProdW'(lim)) begin
        ovf_n = 1'b1;
      end else begin
        acc_n = AccW'(sum);
      end
    end
  end

  // Target range limits.
  always_comb begin
    case (in_ch.target_width)
      Tw8: begin
        pos_lim = Int8Max;
        umax    = Uint8Max;
      end
      Tw16: begin
        pos_lim = Int16Max;
        umax    = Uint16Max;
      end
      default: begin
        pos_lim = Int32Max;
        umax    = Uint32Max;
      end
    endcase
  end

  assign neg_lim = pos_lim + AccW'(1);
  assign sval    = neg_n ? (-acc_n) : acc_n;

  // Truncate to the target width, sign or zero extended, and flag range.
  always_comb begin
    if (is_signed) begin
      err_c = ovf_n || (neg_n ? (acc_n > neg_lim) : (acc_n > pos_lim));
      case (in_ch.target_width)
        Tw8:     value_c = {{(ValW-8){sval[7]}}, sval[7:0]};
        Tw16:    value_c = {{(ValW-16){sval[15]}}, sval[15:0]};
        default: value_c = {{(ValW-32){sval[31]}}, sval[31:0]};
      endcase
    end else begin
      err_c   = ovf_n || (acc_n > umax);
      value_c = acc_n & umax;
    end
  end

  // Next state: the token state clears once its result is produced.
  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    neg_nxt = neg_r;
    pos_nxt = pos_r;
    if (in_beat) begin
      if (in_ch.last_char) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
        neg_nxt = 1'b0;
        pos_nxt = PosFirst;
      end else begin
        acc_nxt = acc_n;
        ovf_nxt = ovf_n;
        neg_nxt = neg_n;
        pos_nxt = (pos_b == PosSat) ? pos_b : pos_b + PosW'(1);
      end
    end
  end

  // Result register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_beat && in_ch.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_beat) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      neg_r       <= 1'b0;
      pos_r       <= PosFirst;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      neg_r       <= neg_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each last-character beat.
  always_ff @(posedge clk) begin
    if (in_beat && in_ch.last_char) begin
      value_r <= $signed(value_c);
      err_r   <= err_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value_out   = value_r;
  assign out_ch.range_error = err_r;

  // The accumulator never grows past the widest limit.
  `ATOI_ASSERT_NOW(a_acc_bound, clk, rst_n, 1'b1, acc_r <= Uint32Max, "accumulator above limit")

  // A last character yields a held result beat and a cleared token state.
  `ATOI_ASSERT_NEXT(a_last_result, clk, rst_n, in_beat && in_ch.last_char, out_valid_r && (acc_r == '0) && !ovf_r && !neg_r && (pos_r == PosFirst), "last beat did not produce result")

  // A held, untaken result blocks the character channel.
  `ATOI_ASSERT_NOW(a_stall_block, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready, "input open while result stalled")

endmodule
